// ===== src/eoe_tx_frame_fragmenter_assert.svh =====
// assertion macros for the eoe transmit fragmenter
// used by modules that check their own logic; needs clk and rst in scope
`ifndef EOE_TX_FRAME_FRAGMENTER_ASSERT_SVH
`define EOE_TX_FRAME_FRAGMENTER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define EOEFRAG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("eoefrag assertion failed");

// next-cycle implication, disabled during reset
`define EOEFRAG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("eoefrag assertion failed");

`endif

// ===== src/eoefrag_pkg.sv =====
// shared types and constants of the eoe transmit fragmenter
// no dependencies
package eoefrag_pkg;

  localparam int LEN_W               = 11;
  localparam int HEADER_BYTES        = 4;
  localparam int OFFSET_SHIFT        = 5;   // offset unit of 32 bytes
  localparam int PHASE_W             = 3;
  localparam int DEF_MAX_FRAME_BYTES = 1518;
  localparam int DEF_QUEUE_DEPTH     = 4;

  localparam logic [LEN_W-1:0] DEF_MAX_FRAGMENT = 11'd132;
  localparam logic [LEN_W-1:0] MIN_FRAGMENT     = 11'd5;
  localparam logic [7:0]       HDR_BYTE0        = 8'h00;
  localparam logic [7:0]       LAST_FRAG_FLAG   = 8'h80;
  localparam logic [5:0]       INDEX_MASK       = 6'h3F;

  typedef struct packed {
    logic [7:0]       data;
    logic             has_header;
    logic [7:0]       hdr1;
    logic [7:0]       hdr2;
    logic [7:0]       hdr3;
    logic [LEN_W-1:0] frag_len;
    logic             frag_end;
    logic             frame_end;
    logic             rejected;
  } cmd_t;

endpackage

// ===== src/eoefrag_in_if.sv =====
// input channel of the fragmenter: frame bytes with start flag and length
// depends on nothing
interface eoefrag_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  in_byte;
  logic        start_of_frame;
  logic [10:0] frame_length;

  modport source (output valid, in_byte, start_of_frame, frame_length, input ready);
  modport sink (input valid, in_byte, start_of_frame, frame_length, output ready);
endinterface

// ===== src/eoefrag_out_if.sv =====
// output channel of the fragmenter: header and payload bytes with markers
// depends on nothing
interface eoefrag_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        is_header;
  logic [10:0] fragment_length;
  logic        fragment_end;
  logic        frame_end;
  logic        rejected;
  logic        run_last;

  modport source (output valid, out_byte, is_header, fragment_length, fragment_end,
                  frame_end, rejected, run_last, input ready);
  modport sink (input valid, out_byte, is_header, fragment_length, fragment_end,
                frame_end, rejected, run_last, output ready);
endinterface

// ===== src/eoefrag_front.sv =====
// front end: accepts frame bytes, tracks frame and fragment state, builds commands
// depends on eoefrag_pkg and eoefrag_in_if
module eoefrag_front #(
  parameter int MAX_FRAME_BYTES = eoefrag_pkg::DEF_MAX_FRAME_BYTES
) (
  input  logic                           clk,
  input  logic                           rst,
  eoefrag_in_if.sink                     in_ch,
  input  logic                           cfg_we,
  input  logic [eoefrag_pkg::LEN_W-1:0]  cfg_data,
  input  logic                           q_ready,
  output logic                           push,
  output eoefrag_pkg::cmd_t              push_cmd
);

  localparam int LW = eoefrag_pkg::LEN_W;

  logic [LW-1:0] max_fragment_bytes;
  logic [LW-1:0] byte_offset, byte_offset_next;
  logic [LW-1:0] bytes_left_in_frame, bytes_left_in_frame_next;
  logic [LW-1:0] bytes_left_in_fragment, bytes_left_in_fragment_next;
  logic [5:0]    fragment_index, fragment_index_next;
  logic [1:0]    frame_counter, frame_counter_next;
  logic          dropping_frame, dropping_frame_next;
  logic [LW-1:0] fragment_bytes, fragment_bytes_next;

  logic          accept, sof, bad_len, active, new_frag, last;
  logic [LW-1:0] eff_left, eff_frag_left, eff_offset, eff_m, cap, pay;
  logic [LW-1:0] frag_base, cur_len;
  logic [5:0]    eff_index;
  logic [1:0]    eff_counter;

  assign in_ch.ready = q_ready;
  assign accept      = in_ch.valid && q_ready;
  assign sof         = in_ch.start_of_frame;
  assign bad_len     = (in_ch.frame_length == '0) ||
                       (in_ch.frame_length > LW'(MAX_FRAME_BYTES));

  always_comb begin
    eff_left      = sof ? in_ch.frame_length : bytes_left_in_frame;
    eff_frag_left = sof ? '0 : bytes_left_in_fragment;
    eff_offset    = sof ? '0 : byte_offset;
    eff_index     = sof ? '0 : fragment_index;
    eff_counter   = sof ? frame_counter + 2'd1 : frame_counter;
    active        = sof || (!dropping_frame && bytes_left_in_frame != '0);
    new_frag      = (eff_frag_left == '0);
    eff_m         = (max_fragment_bytes < eoefrag_pkg::MIN_FRAGMENT) ?
                    eoefrag_pkg::MIN_FRAGMENT : max_fragment_bytes;
    cap           = eff_m - LW'(eoefrag_pkg::HEADER_BYTES);
    pay           = (eff_left < cap) ? eff_left : cap;
    last          = (pay == eff_left);
    cur_len       = new_frag ? pay + LW'(eoefrag_pkg::HEADER_BYTES) : fragment_bytes;
    frag_base     = new_frag ? pay : eff_frag_left;

    push_cmd.data       = in_ch.in_byte;
    push_cmd.has_header = new_frag;
    push_cmd.hdr1       = (last ? eoefrag_pkg::LAST_FRAG_FLAG : 8'h00) |
                          {2'b00, eff_index & eoefrag_pkg::INDEX_MASK};
    push_cmd.hdr2       = 8'(eff_offset >> eoefrag_pkg::OFFSET_SHIFT);
    push_cmd.hdr3       = {eff_counter,
                           6'(eff_offset >> (eoefrag_pkg::OFFSET_SHIFT + 8))};
    push_cmd.frag_len   = cur_len;
    push_cmd.frag_end   = (frag_base - LW'(1)) == '0;
    push_cmd.frame_end  = (eff_left - LW'(1)) == '0;
    push_cmd.rejected   = 1'b0;

    byte_offset_next            = byte_offset;
    bytes_left_in_frame_next    = bytes_left_in_frame;
    bytes_left_in_fragment_next = bytes_left_in_fragment;
    fragment_index_next         = fragment_index;
    frame_counter_next          = frame_counter;
    dropping_frame_next         = dropping_frame;
    fragment_bytes_next         = fragment_bytes;
    push                        = 1'b0;

    if (accept) begin
      if (sof && bad_len) begin
        push_cmd                    = '0;
        push_cmd.rejected           = 1'b1;
        push                        = 1'b1;
        dropping_frame_next         = 1'b1;
        bytes_left_in_frame_next    = '0;
        bytes_left_in_fragment_next = '0;
      end else if (active) begin
        push                        = 1'b1;
        dropping_frame_next         = 1'b0;
        frame_counter_next          = eff_counter;
        byte_offset_next            = eff_offset + LW'(1);
        bytes_left_in_frame_next    = eff_left - LW'(1);
        bytes_left_in_fragment_next = frag_base - LW'(1);
        fragment_index_next         = new_frag ? eff_index + 6'd1 : eff_index;
        fragment_bytes_next         = cur_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_fragment_bytes     <= eoefrag_pkg::DEF_MAX_FRAGMENT;
      byte_offset            <= '0;
      bytes_left_in_frame    <= '0;
      bytes_left_in_fragment <= '0;
      fragment_index         <= '0;
      frame_counter          <= '0;
      dropping_frame         <= 1'b0;
      fragment_bytes         <= '0;
    end else begin
      if (cfg_we) begin
        max_fragment_bytes <= cfg_data;
      end
      byte_offset            <= byte_offset_next;
      bytes_left_in_frame    <= bytes_left_in_frame_next;
      bytes_left_in_fragment <= bytes_left_in_fragment_next;
      fragment_index         <= fragment_index_next;
      frame_counter          <= frame_counter_next;
      dropping_frame         <= dropping_frame_next;
      fragment_bytes         <= fragment_bytes_next;
    end
  end

endmodule

// ===== src/eoefrag_queue.sv =====
// short command queue between front and back end
// depends on eoefrag_pkg
module eoefrag_queue #(
  parameter int DEPTH = eoefrag_pkg::DEF_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  eoefrag_pkg::cmd_t push_cmd,
  output logic              q_ready,
  output logic              q_valid,
  output eoefrag_pkg::cmd_t q_cmd,
  input  logic              pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  eoefrag_pkg::cmd_t entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push, do_pop;

  assign q_ready = (count != CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign q_cmd   = entries[rd_ptr];
  assign do_push = push && q_ready;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== src/eoefrag_back.sv =====
// back end: expands commands into header and payload bytes, output register
// depends on eoefrag_pkg, eoefrag_out_if and the assertion macro header
`include "eoe_tx_frame_fragmenter_assert.svh"

module eoefrag_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  eoefrag_pkg::cmd_t q_cmd,
  output logic              pop,
  eoefrag_out_if.source     out_ch
);

  localparam int PW = eoefrag_pkg::PHASE_W;
  localparam int LW = eoefrag_pkg::LEN_W;

  logic [PW-1:0] phase, phase_next;
  logic          load, emit;
  logic [7:0]    e_byte, hdr_byte;
  logic          e_hdr, e_fend, e_frend, e_rej, e_last;
  logic [LW-1:0] e_len;

  logic          valid;
  logic [7:0]    out_byte;
  logic          is_header, fragment_end, frame_end, rejected, run_last;
  logic [LW-1:0] fragment_length;

  assign load = !valid || out_ch.ready;
  assign emit = load && q_valid;

  always_comb begin
    case (phase[1:0])
      2'd0:    hdr_byte = eoefrag_pkg::HDR_BYTE0;
      2'd1:    hdr_byte = q_cmd.hdr1;
      2'd2:    hdr_byte = q_cmd.hdr2;
      default: hdr_byte = q_cmd.hdr3;
    endcase

    e_byte     = q_cmd.data;
    e_hdr      = 1'b0;
    e_len      = q_cmd.frag_len;
    e_fend     = q_cmd.frag_end;
    e_frend    = q_cmd.frame_end;
    e_rej      = 1'b0;
    e_last     = 1'b1;
    pop        = emit;
    phase_next = '0;

    if (q_cmd.rejected) begin
      e_byte  = '0;
      e_len   = '0;
      e_fend  = 1'b0;
      e_frend = 1'b0;
      e_rej   = 1'b1;
    end else if (q_cmd.has_header && phase != PW'(eoefrag_pkg::HEADER_BYTES)) begin
      e_byte     = hdr_byte;
      e_hdr      = 1'b1;
      e_fend     = 1'b0;
      e_frend    = 1'b0;
      e_last     = 1'b0;
      pop        = 1'b0;
      phase_next = phase + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      phase <= '0;
    end else if (load) begin
      valid <= q_valid;
      if (q_valid) begin
        phase <= phase_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte        <= e_byte;
      is_header       <= e_hdr;
      fragment_length <= e_len;
      fragment_end    <= e_fend;
      frame_end       <= e_frend;
      rejected        <= e_rej;
      run_last        <= e_last;
    end
  end

  assign out_ch.valid           = valid;
  assign out_ch.out_byte        = out_byte;
  assign out_ch.is_header       = is_header;
  assign out_ch.fragment_length = fragment_length;
  assign out_ch.fragment_end    = fragment_end;
  assign out_ch.frame_end       = frame_end;
  assign out_ch.rejected        = rejected;
  assign out_ch.run_last        = run_last;

  `EOEFRAG_ASSERT_IMP(a_hdr_holds_item, phase != '0, q_valid)
  `EOEFRAG_ASSERT_IMP(a_rej_single, valid && rejected, run_last && !is_header)
  `EOEFRAG_ASSERT_IMP(a_hdr_no_end, valid && is_header, !fragment_end && !frame_end && !run_last)
  `EOEFRAG_ASSERT_NXT(a_hdr_then_next, emit && e_hdr, phase == $past(phase) + PW'(1))

endmodule

// ===== src/eoe_tx_frame_fragmenter.sv =====
// eoe transmit frame fragmenter, top level
// depends on eoefrag_pkg, both channel interfaces, front, queue and back modules
//
// in_ch carries frame bytes; start_of_frame marks the first byte and frame_length
// gives the frame size. out_ch carries the fragment stream: for each fragment four
// header bytes (is_header high) and then the payload bytes, with fragment_end and
// frame_end on the last bytes; a frame of length 0 or above MAX_FRAME_BYTES gives a
// single item with rejected high and its bytes are dropped. run_last marks the last
// output item caused by an input item. cfg_we/cfg_data write max_fragment_bytes
// (header included, values below 5 act as 5); the user must write it only while the
// block is idle, which the block itself does not enforce. throughput: one input item
// per cycle inside a fragment while the queue has room; an item that opens a
// fragment holds the output register for four header items and its payload item, and
// the register emits one item per cycle while the receiver is ready. the command
// queue (QUEUE_DEPTH entries) absorbs the header bursts, so input is held off only
// once the queue fills. when the receiver stalls, the output register holds its item
// and the queue fills, then in_ch.ready drops.
// reset clears all frame state, empties the queue and loads max_fragment_bytes = 132.
module eoe_tx_frame_fragmenter #(
  parameter int MAX_FRAME_BYTES = eoefrag_pkg::DEF_MAX_FRAME_BYTES,
  parameter int QUEUE_DEPTH     = eoefrag_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  eoefrag_in_if.sink                    in_ch,
  eoefrag_out_if.source                 out_ch,
  input  logic                          cfg_we,
  input  logic [eoefrag_pkg::LEN_W-1:0] cfg_data
);

  logic              push, q_ready, q_valid, pop;
  eoefrag_pkg::cmd_t push_cmd, q_cmd;

  eoefrag_front #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_ready  (q_ready),
    .push     (push),
    .push_cmd (push_cmd)
  );

  eoefrag_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .q_ready  (q_ready),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop)
  );

  eoefrag_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
